[hdl/ps2hl_pkg.sv]
// Shared types, codes and constants for the PS/2 host link.
package ps2hl_pkg;

   localparam int FIFO_DEPTH_DEF = 16;

   localparam logic [15:0] TIMEOUT_RESET = 16'd250;

   // frame positions of the bit counter
   localparam logic [3:0] PARITY_INDEX  = 4'd8;
   localparam logic [3:0] RELEASE_INDEX = 4'd9;
   localparam logic [3:0] STOP_INDEX    = 4'd10;
   localparam logic [3:0] FRAME_END     = 4'd11;
   localparam logic [3:0] PARKED_INDEX  = 4'd12;

   localparam logic [15:0] IDLE_MAX  = 16'hFFFF;
   localparam logic [3:0]  COUNT_MAX = 4'd15;

   // event codes on the request side
   localparam logic [2:0] FUNC_EDGE  = 3'd0;
   localparam logic [2:0] FUNC_TICK  = 3'd1;
   localparam logic [2:0] FUNC_WRITE = 3'd2;
   localparam logic [2:0] FUNC_POP   = 3'd3;
   localparam logic [2:0] FUNC_FLUSH = 3'd4;

   // status codes on the response side
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_CLOCK_LOW = 2'd2;
   localparam logic [1:0] STATUS_BUSY      = 2'd3;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_EDGE,
      CMD_TICK,
      CMD_WRITE,
      CMD_POP,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         data_level;
      logic         clock_level;
      logic [7:0]   tx_byte;
   } cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] rx_byte;
      logic       data_drive_low;
      logic       clock_inhibit;
      logic       tx_active;
      logic [3:0] fifo_count;
   } rsp_type;

endpackage

[hdl/ps2hl_queue.sv]
// Two-entry register queue used between the link stages.
module ps2hl_queue
   import ps2hl_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign dout  = head_ff;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_in = din;
         end else begin
            head_in = tail_ff;
            tail_in = din;
         end
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = din;
         end else begin
            tail_in = din;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_shift_up: assert property (@(posedge clock) disable iff (reset)
      (pop && !push && count_ff == 2'd2) |=> (dout == $past(tail_ff)))
      else $error("queue lost second entry on pop");

endmodule

[hdl/ps2hl_front.sv]
// Front end: takes request words and classifies them into link commands.
module ps2hl_front
   import ps2hl_pkg::*;
(
   input  logic       req_push,
   input  logic [2:0] req_func,
   input  logic       req_data_level,
   input  logic       req_clock_level,
   input  logic [7:0] req_tx_byte,
   input  logic       queue_full,
   output logic       queue_push,
   output cmd_type    cmd
);

   assign queue_push = req_push && !queue_full;

   always_comb begin
      cmd.data_level  = req_data_level;
      cmd.clock_level = req_clock_level;
      cmd.tx_byte     = req_tx_byte;
      case (req_func)
         FUNC_EDGE:  cmd.kind = CMD_EDGE;
         FUNC_TICK:  cmd.kind = CMD_TICK;
         FUNC_WRITE: cmd.kind = CMD_WRITE;
         FUNC_POP:   cmd.kind = CMD_POP;
         FUNC_FLUSH: cmd.kind = CMD_FLUSH;
         default:    cmd.kind = CMD_NOP;
      endcase
   end

endmodule

[hdl/ps2hl_back.sv]
// Back end: frame engine, receive byte ring and response stage.
module ps2hl_back
   import ps2hl_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  logic        csr_we,
   input  logic [15:0] csr_data,
   input  logic        out_full,
   output logic        out_push,
   output rsp_type     out_rsp
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int UW    = PTR_W + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [15:0]      timeout_ff;
   logic [3:0]       bit_index_ff, bit_index_in;
   logic [7:0]       shift_ff, shift_in;
   logic             parity_ff, parity_in;
   logic             sending_ff, sending_in;
   logic             drive_ff, drive_in;
   logic [15:0]      idle_ff, idle_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]       mem [FIFO_DEPTH];
   logic [7:0]       rd_data_ff;

   logic             s2_valid_ff;
   rsp_type          s2_rsp_ff;
   logic             s2_pop_ok_ff;

   logic             fire;
   logic             timed_out;
   logic             mem_we;
   logic             pop_ok;
   logic [1:0]       status;
   logic             inhibit;
   logic [PTR_W-1:0] nxt_wr, nxt_rd;
   logic [UW-1:0]    w_ext, r_ext, used;
   logic [3:0]       count;

   assign out_push  = s2_valid_ff && !out_full;
   assign fire      = cmd_valid && (!s2_valid_ff || out_push);
   assign cmd_pop   = fire;
   assign timed_out = (idle_ff >= timeout_ff);

   assign nxt_wr = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign nxt_rd = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      parity_in    = parity_ff;
      sending_in   = sending_ff;
      drive_in     = drive_ff;
      idle_in      = idle_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      mem_we       = 1'b0;
      pop_ok       = 1'b0;
      status       = STATUS_OK;
      inhibit      = 1'b0;
      if (fire) begin
         case (cmd.kind)
            CMD_EDGE: begin
               if (timed_out) begin
                  bit_index_in = '0;
                  if (sending_ff) begin
                     sending_in = 1'b0;
                     drive_in   = 1'b0;
                  end
               end
               if (sending_in) begin
                  if (bit_index_in < PARITY_INDEX) begin
                     drive_in  = ~shift_ff[0];
                     parity_in = parity_ff ^ shift_ff[0];
                     shift_in  = {1'b0, shift_ff[7:1]};
                  end else if (bit_index_in == PARITY_INDEX) begin
                     drive_in = ~parity_ff;
                  end else if (bit_index_in == RELEASE_INDEX) begin
                     drive_in = 1'b0;
                  end
                  bit_index_in = bit_index_in + 4'd1;
                  if (bit_index_in >= FRAME_END) begin
                     sending_in   = 1'b0;
                     drive_in     = 1'b0;
                     bit_index_in = '0;
                  end
               end else begin
                  if (bit_index_in >= FRAME_END) begin
                     bit_index_in = PARKED_INDEX;
                  end else if (bit_index_in == 4'd0) begin
                     // start bit: must be low, otherwise park until timeout
                     shift_in     = '0;
                     parity_in    = 1'b1;
                     bit_index_in = cmd.data_level ? PARKED_INDEX : 4'd1;
                  end else begin
                     if (bit_index_in <= PARITY_INDEX) begin
                        shift_in  = {cmd.data_level, shift_ff[7:1]};
                        parity_in = parity_ff ^ cmd.data_level;
                     end
                     bit_index_in = bit_index_in + 4'd1;
                     if (bit_index_in == FRAME_END) begin
                        // stop bit high and room left: keep the byte
                        if (cmd.data_level && (nxt_wr != rd_ptr_ff)) begin
                           mem_we    = 1'b1;
                           wr_ptr_in = nxt_wr;
                        end
                        bit_index_in = '0;
                     end
                  end
               end
               idle_in = '0;
            end
            CMD_TICK: begin
               if (idle_ff != IDLE_MAX) begin
                  idle_in = idle_ff + 16'd1;
               end
            end
            CMD_WRITE: begin
               if (((bit_index_ff != 4'd0) || sending_ff) && !timed_out) begin
                  status = STATUS_BUSY;
               end else if (!cmd.clock_level) begin
                  status = STATUS_CLOCK_LOW;
               end else begin
                  sending_in   = 1'b1;
                  shift_in     = cmd.tx_byte;
                  bit_index_in = '0;
                  parity_in    = 1'b1;
                  drive_in     = 1'b1;
                  idle_in      = '0;
                  inhibit      = 1'b1;
               end
            end
            CMD_POP: begin
               if (wr_ptr_ff == rd_ptr_ff) begin
                  status = STATUS_EMPTY;
               end else begin
                  pop_ok    = 1'b1;
                  rd_ptr_in = nxt_rd;
               end
            end
            CMD_FLUSH: begin
               rd_ptr_in = wr_ptr_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // occupancy after the event, clipped to the port width
   always_comb begin
      w_ext = UW'(wr_ptr_in);
      r_ext = UW'(rd_ptr_in);
      if (w_ext >= r_ext) begin
         used = w_ext - r_ext;
      end else begin
         used = w_ext + UW'(FIFO_DEPTH) - r_ext;
      end
      count = (used > UW'(COUNT_MAX)) ? COUNT_MAX : 4'(used);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         parity_ff    <= 1'b1;
         sending_ff   <= 1'b0;
         drive_ff     <= 1'b0;
         idle_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         s2_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_data;
         end
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         parity_ff    <= parity_in;
         sending_ff   <= sending_in;
         drive_ff     <= drive_in;
         idle_ff      <= idle_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         if (fire) begin
            s2_valid_ff <= 1'b1;
         end else if (out_push) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   // response stage payload
   always_ff @(posedge clock) begin
      if (fire) begin
         s2_rsp_ff.status         <= status;
         s2_rsp_ff.rx_byte        <= '0;
         s2_rsp_ff.data_drive_low <= drive_in;
         s2_rsp_ff.clock_inhibit  <= inhibit;
         s2_rsp_ff.tx_active      <= sending_in;
         s2_rsp_ff.fifo_count     <= count;
         s2_pop_ok_ff             <= pop_ok;
      end
   end

   // receive byte ring
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= shift_in;
      end
      if (pop_ok) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_comb begin
      out_rsp         = s2_rsp_ff;
      out_rsp.rx_byte = s2_pop_ok_ff ? rd_data_ff : 8'd0;
   end

   a_index_legal: assert property (@(posedge clock) disable iff (reset)
      (bit_index_ff <= STOP_INDEX) || (bit_index_ff == PARKED_INDEX))
      else $error("bit counter left the frame");

   a_drive_needs_tx: assert property (@(posedge clock) disable iff (reset)
      drive_ff |-> sending_ff)
      else $error("data line driven outside a transmit");

   a_tx_index: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (bit_index_ff < FRAME_END))
      else $error("transmit counter past frame end");

   a_inhibit_ok: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_rsp_ff.clock_inhibit) |-> (s2_rsp_ff.status == STATUS_OK))
      else $error("clock inhibit on a refused write");

endmodule

[hdl/ps2_host_link_core.sv]
// Top level of the PS/2 host link: request front end, command queue, back end.
//
// PS/2 host link. Each request word is one event (falling clock edge with the
// sampled data level, millisecond tick, write request, receive pop or flush)
// and yields exactly one response word, in request order. The core accepts one
// event per clock while responses drain: the front end classifies a word into
// a two-entry command queue, and the back end applies one command per cycle to
// the frame state and the receive byte ring, then registers the response into
// a two-entry response queue. A word passes the command queue, the response
// register and the response queue before it shows on the rsp_ ports; the rate
// is set by the back end's frame update, and the ring's registered read port
// loads on the same edge as the response register, so it adds no stage.
// Received bytes are kept only with a high stop bit and room in the ring, which
// holds FIFO_DEPTH-1 bytes; fifo_count clips at 15. timeout_ticks (csr_data,
// reset 250) is the idle tick count after which the next edge restarts framing
// and aborts a transmit; write it only while the core is idle. The ring has no
// reset sweep, so the core takes events right after reset.
module ps2_host_link_core
   import ps2hl_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // request word channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_func,
   input  logic        req_data_level,
   input  logic        req_clock_level,
   input  logic [7:0]  req_tx_byte,

   // response word channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_data_drive_low,
   output logic        rsp_clock_inhibit,
   output logic        rsp_tx_active,
   output logic [3:0]  rsp_fifo_count,

   // timeout register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cmd_type    front_cmd;
   logic       front_push;
   logic       cmdq_full;
   logic       cmdq_empty;
   logic [CMD_W-1:0] cmdq_dout;
   logic       cmd_pop;

   logic       out_push;
   logic       outq_full;
   rsp_type    back_rsp;
   logic [RSP_W-1:0] outq_dout;
   rsp_type    head_rsp;

   // the register is always writable
   assign csr_ready = 1'b1;
   assign req_full  = cmdq_full;

   ps2hl_front u_front (
      .req_push        (req_push),
      .req_func        (req_func),
      .req_data_level  (req_data_level),
      .req_clock_level (req_clock_level),
      .req_tx_byte     (req_tx_byte),
      .queue_full      (cmdq_full),
      .queue_push      (front_push),
      .cmd             (front_cmd)
   );

   ps2hl_queue #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .din   (front_cmd),
      .full  (cmdq_full),
      .pop   (cmd_pop),
      .dout  (cmdq_dout),
      .empty (cmdq_empty)
   );

   ps2hl_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmdq_empty),
      .cmd       (cmd_type'(cmdq_dout)),
      .cmd_pop   (cmd_pop),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .out_full  (outq_full),
      .out_push  (out_push),
      .out_rsp   (back_rsp)
   );

   // response queue: a finished word waits here while new events proceed
   ps2hl_queue #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (back_rsp),
      .full  (outq_full),
      .pop   (rsp_pop && !rsp_empty),
      .dout  (outq_dout),
      .empty (rsp_empty)
   );

   assign head_rsp           = rsp_type'(outq_dout);
   assign rsp_status         = head_rsp.status;
   assign rsp_rx_byte        = head_rsp.rx_byte;
   assign rsp_data_drive_low = head_rsp.data_drive_low;
   assign rsp_clock_inhibit  = head_rsp.clock_inhibit;
   assign rsp_tx_active      = head_rsp.tx_active;
   assign rsp_fifo_count     = head_rsp.fifo_count;

endmodule
